// ===== hdl/pl1dm_pkg.sv =====
package pl1dm_pkg;

    localparam int MAX_PEOPLE_DEF   = 64;
    localparam int MAX_FEATURES_DEF = 16;
    localparam int RATING_BITS_DEF  = 8;

    localparam int FC_W   = 5;
    localparam int DIST_W = 12;

    localparam logic [FC_W-1:0]   FC_RESET = 5'd16;
    localparam logic [DIST_W-1:0] DIST_MAX = 12'hFFF;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [5:0] person;
        logic [3:0] feature;
        logic [7:0] rating;
        logic [5:0] partner;
    } in_req_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              is_self;
    } out_rsp_t;

    // sequencer to accumulator controls
    typedef struct packed {
        logic clear;
        logic add;
        logic zero_a;
        logic zero_b;
    } accum_ctrl_t;

endpackage

// ===== hdl/pairwise_l1_distance_matrix_unit.sv =====
// Load request: loads may arrive every cycle while no query is in progress.
// Query request: n = min(feature_count, MAX_FEATURES) feature pairs are summed, none when n is 0
// or the query names the same person twice.
// One feature pair is read per cycle from the dual-read rating memory into one shared
// abs-difference accumulator; input is not ready until the result is registered.
// Reset (rst_n, async, active low) clears control state and sets feature_count to 16.
module pairwise_l1_distance_matrix_unit #(
    parameter int MAX_PEOPLE   = pl1dm_pkg::MAX_PEOPLE_DEF,
    parameter int MAX_FEATURES = pl1dm_pkg::MAX_FEATURES_DEF,
    parameter int RATING_BITS  = pl1dm_pkg::RATING_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  pl1dm_pkg::in_req_t          in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output pl1dm_pkg::out_rsp_t         out_data,
    input  logic                        cfg_we,
    input  logic [pl1dm_pkg::FC_W-1:0]  cfg_wdata
);

    localparam int DEPTH  = MAX_PEOPLE * MAX_FEATURES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(MAX_FEATURES + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]                   state_reg, state_next;
    logic [pl1dm_pkg::FC_W-1:0]   fc_reg;
    logic [CNT_W-1:0]             n_reg;
    logic [CNT_W-1:0]             issue_cnt_reg;
    logic [ADDR_W-1:0]            a_addr_reg;
    logic [ADDR_W-1:0]            b_addr_reg;
    logic                         zero_a_reg;
    logic                         zero_b_reg;
    logic                         self_reg;
    logic                         rd_valid_reg;
    logic                         out_valid_reg;
    pl1dm_pkg::out_rsp_t          out_data_reg;

    logic                         accept;
    logic                         is_query;
    logic                         person_ok;
    logic                         partner_ok;
    logic                         feature_ok;
    logic                         is_self;
    logic [CNT_W-1:0]             n_clamped;
    logic                         issue;
    logic                         store_we;
    logic [ADDR_W-1:0]            store_waddr;
    logic [RATING_BITS-1:0]       rdata_a;
    logic [RATING_BITS-1:0]       rdata_b;
    logic [pl1dm_pkg::DIST_W-1:0] acc;
    pl1dm_pkg::accum_ctrl_t       actrl;
    logic                         out_load;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign is_query  = (in_data.operation == pl1dm_pkg::OP_QUERY);
    assign person_ok  = (32'(in_data.person) < 32'(MAX_PEOPLE));
    assign partner_ok = (32'(in_data.partner) < 32'(MAX_PEOPLE));
    assign feature_ok = (32'(in_data.feature) < 32'(MAX_FEATURES));
    assign is_self    = (in_data.person == in_data.partner);

    assign n_clamped = (32'(fc_reg) > 32'(MAX_FEATURES)) ? CNT_W'(MAX_FEATURES)
                                                         : CNT_W'(fc_reg);

    assign store_we    = accept && (in_data.operation == pl1dm_pkg::OP_LOAD)
                         && person_ok && feature_ok;
    assign store_waddr = ADDR_W'(int'(in_data.person) * MAX_FEATURES
                                 + int'(in_data.feature));

    assign issue = (state_reg == ST_RUN) && (issue_cnt_reg < n_reg);

    assign actrl.clear  = accept && is_query;
    assign actrl.add    = rd_valid_reg;
    assign actrl.zero_a = zero_a_reg;
    assign actrl.zero_b = zero_b_reg;

    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    pl1dm_store #(
        .DEPTH  (DEPTH),
        .DATA_W (RATING_BITS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .we      (store_we),
        .waddr   (store_waddr),
        .wdata   (RATING_BITS'(in_data.rating)),
        .re      (issue),
        .raddr_a (a_addr_reg),
        .raddr_b (b_addr_reg),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    pl1dm_accum #(
        .RATING_BITS (RATING_BITS)
    ) u_accum (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (actrl),
        .a     (rdata_a),
        .b     (rdata_b),
        .acc   (acc)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_query)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                // all reads issued and the last one added
                if (issue_cnt_reg == n_reg && !rd_valid_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fc_reg        <= pl1dm_pkg::FC_RESET;
            n_reg         <= '0;
            issue_cnt_reg <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            self_reg      <= 1'b0;
            zero_a_reg    <= 1'b0;
            zero_b_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= issue;
            if (cfg_we)
            begin
                fc_reg <= cfg_wdata;
            end
            if (accept && is_query)
            begin
                n_reg         <= is_self ? '0 : n_clamped;
                issue_cnt_reg <= '0;
                self_reg      <= is_self;
                zero_a_reg    <= !person_ok;
                zero_b_reg    <= !partner_ok;
            end
            else if (issue)
            begin
                issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_query)
        begin
            // out-of-range people point at entry 0; their data is zeroed later
            a_addr_reg <= person_ok  ? ADDR_W'(int'(in_data.person) * MAX_FEATURES)  : '0;
            b_addr_reg <= partner_ok ? ADDR_W'(int'(in_data.partner) * MAX_FEATURES) : '0;
        end
        else if (issue)
        begin
            a_addr_reg <= a_addr_reg + ADDR_W'(1);
            b_addr_reg <= b_addr_reg + ADDR_W'(1);
        end
        if (out_load)
        begin
            out_data_reg.distance <= self_reg ? pl1dm_pkg::DIST_MAX : acc;
            out_data_reg.is_self  <= self_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_self_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && self_reg |=> out_data.distance == pl1dm_pkg::DIST_MAX)
        else $error("self result without all-ones distance");

    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> issue_cnt_reg <= n_reg)
        else $error("feature reads ran past the feature count");

    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !rd_valid_reg && !issue)
        else $error("memory read pending while idle");

    a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINISH && !out_load |=> state_reg == ST_FINISH && out_valid)
        else $error("finished result dropped while output busy");

endmodule

// ===== hdl/pl1dm_store.sv =====
module pl1dm_store #(
    parameter int DEPTH  = pl1dm_pkg::MAX_PEOPLE_DEF * pl1dm_pkg::MAX_FEATURES_DEF,
    parameter int DATA_W = pl1dm_pkg::RATING_BITS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [DATA_W-1:0] rdata_a,
    output logic [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ===== hdl/pl1dm_accum.sv =====
module pl1dm_accum #(
    parameter int RATING_BITS = pl1dm_pkg::RATING_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pl1dm_pkg::accum_ctrl_t        ctrl,
    input  logic [RATING_BITS-1:0]        a,
    input  logic [RATING_BITS-1:0]        b,
    output logic [pl1dm_pkg::DIST_W-1:0]  acc
);

    localparam int SUM_W =
        (RATING_BITS > pl1dm_pkg::DIST_W ? RATING_BITS : pl1dm_pkg::DIST_W) + 1;

    logic [pl1dm_pkg::DIST_W-1:0] acc_reg;
    logic [pl1dm_pkg::DIST_W-1:0] acc_next;
    logic [RATING_BITS-1:0]       a_in;
    logic [RATING_BITS-1:0]       b_in;
    logic [RATING_BITS-1:0]       diff;
    logic [SUM_W-1:0]             sum;

    always_comb
    begin
        // out-of-range people read as zero
        a_in = ctrl.zero_a ? '0 : a;
        b_in = ctrl.zero_b ? '0 : b;
        diff = (a_in >= b_in) ? (a_in - b_in) : (b_in - a_in);
        sum  = SUM_W'(acc_reg) + SUM_W'(diff);
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (ctrl.add)
        begin
            acc_next = (sum > SUM_W'(pl1dm_pkg::DIST_MAX)) ? pl1dm_pkg::DIST_MAX
                                                           : pl1dm_pkg::DIST_W'(sum);
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule
